// ===== sv/clf_pkg.sv =====
// Shared types and constants for the command line framer.
package clf_pkg;

    localparam int LEN_W = 5;

    localparam logic [7:0] CH_START = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] PART_CMD = 2'd0;
    localparam logic [1:0] PART_PAR = 2'd1;
    localparam logic [1:0] PART_END = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CMD,
        PH_GAP,
        PH_PARAM
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CMD,
        BK_PAR,
        BK_END
    } t_emit;

    typedef struct packed {
        logic             has_param;
        logic [LEN_W-1:0] cmd_len;
        logic [LEN_W-1:0] par_len;
    } t_job;

    typedef struct packed {
        logic             we_cmd;
        logic             we_par;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } t_st_wr;

endpackage

// ===== sv/command_line_framer.sv =====
// Top level of the command line framer: parser, descriptor queue and emitter.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | i_valid / o_ready   | i_in_char
//  out     | output    | o_valid / i_ready   | o_part, o_out_char, o_has_param, o_last
//
// A byte that only hunts for '>' or skips a space is taken every cycle.
// A byte that writes a store or ends a command waits until the emitter has no run
// queued or in progress; each character of a run passes fetch, registered store read and
// the output register, and the next is fetched only once the output register is empty.
// Reset (synchronous, active low) clears parser phase, queue and emitter; stores need none.
// A stalled output holds its record; the parser keeps taking hunt bytes and spaces in the gap.
module command_line_framer #(
    parameter int CMD_CHARS   = 16,
    parameter int PARAM_CHARS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_part,
    output logic [7:0] o_out_char,
    output logic       o_has_param,
    output logic       o_last
);
    import clf_pkg::*;

    t_st_wr st_wr;
    t_job   push_job, q_job;
    logic   push, pop, q_valid, bk_idle, quiet;

    assign quiet = bk_idle && !q_valid;

    clf_front #(
        .CMD_CHARS  (CMD_CHARS),
        .PARAM_CHARS(PARAM_CHARS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_in_char(i_in_char),
        .i_quiet  (quiet),
        .o_st_wr  (st_wr),
        .o_push   (push),
        .o_job    (push_job)
    );

    clf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_job  (q_job)
    );

    clf_back #(
        .CMD_CHARS  (CMD_CHARS),
        .PARAM_CHARS(PARAM_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_st_wr    (st_wr),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_pop      (pop),
        .o_idle     (bk_idle),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_part     (o_part),
        .o_out_char (o_out_char),
        .o_has_param(o_has_param),
        .o_last     (o_last)
    );

endmodule

// ===== sv/clf_front.sv =====
// Byte parser: classifies terminal bytes, writes the stores, posts finished commands.
module clf_front #(
    parameter int CMD_CHARS   = 16,
    parameter int PARAM_CHARS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_in_char,
    input  logic           i_quiet,
    output clf_pkg::t_st_wr o_st_wr,
    output logic           o_push,
    output clf_pkg::t_job  o_job
);
    import clf_pkg::*;

    localparam int MAXC = (CMD_CHARS > PARAM_CHARS) ? CMD_CHARS : PARAM_CHARS;
    localparam int IW   = $clog2(MAXC);

    t_phase          r_ph, n_ph;
    logic [IW-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0] r_cmd_len, n_cmd_len;

    logic line_end, is_start, is_space, needs_back, take;

    assign line_end = (i_in_char == CH_CR) || (i_in_char == CH_LF);
    assign is_start = (i_in_char == CH_START);
    assign is_space = (i_in_char == CH_SPACE);

    // anything that touches the stores or posts a run waits for the back end to drain
    assign needs_back = (r_ph != PH_HUNT) && !((r_ph == PH_GAP) && is_space);
    assign o_ready    = !needs_back || i_quiet;
    assign take       = i_valid && o_ready;

    // next phase
    always_comb begin
        n_ph = r_ph;
        if (take) begin
            case (r_ph)
                PH_HUNT: if (is_start) n_ph = PH_CMD;
                PH_CMD: begin
                    if (is_space)      n_ph = PH_GAP;
                    else if (is_start) n_ph = PH_CMD;
                    else if (line_end) n_ph = PH_HUNT;
                end
                PH_GAP: begin
                    if (is_space)      n_ph = PH_GAP;
                    else if (is_start) n_ph = PH_CMD;
                    else if (line_end) n_ph = PH_HUNT;
                    else               n_ph = PH_PARAM;
                end
                PH_PARAM: begin
                    if (is_start)                  n_ph = PH_CMD;
                    else if (is_space || line_end) n_ph = PH_HUNT;
                end
                default: n_ph = PH_HUNT;
            endcase
        end
    end

    // store writes, index and job posting
    always_comb begin
        n_idx     = r_idx;
        n_cmd_len = r_cmd_len;
        o_st_wr   = '0;
        o_st_wr.data = i_in_char;
        o_push    = 1'b0;
        o_job     = '0;
        if (take) begin
            case (r_ph)
                PH_HUNT: if (is_start) n_idx = '0;
                PH_CMD: begin
                    if (is_space) begin
                        n_cmd_len = LEN_W'(r_idx);
                    end else if (is_start || line_end) begin
                        n_cmd_len     = LEN_W'(r_idx);
                        o_push        = 1'b1;
                        o_job.cmd_len = LEN_W'(r_idx);
                        n_idx         = '0;
                    end else if (r_idx < IW'(CMD_CHARS - 1)) begin
                        o_st_wr.we_cmd = 1'b1;
                        o_st_wr.addr   = LEN_W'(r_idx);
                        n_idx          = r_idx + 1'b1;
                    end
                end
                PH_GAP: begin
                    if (is_start || line_end) begin
                        o_push        = 1'b1;
                        o_job.cmd_len = r_cmd_len;
                        n_idx         = '0;
                    end else if (!is_space) begin
                        o_st_wr.we_par = 1'b1;
                        o_st_wr.addr   = '0;
                        n_idx          = IW'(1);
                    end
                end
                PH_PARAM: begin
                    if (is_start || is_space || line_end) begin
                        o_push          = 1'b1;
                        o_job.has_param = 1'b1;
                        o_job.cmd_len   = r_cmd_len;
                        o_job.par_len   = LEN_W'(r_idx);
                        n_idx           = '0;
                    end else if (r_idx < IW'(PARAM_CHARS - 1)) begin
                        o_st_wr.we_par = 1'b1;
                        o_st_wr.addr   = LEN_W'(r_idx);
                        n_idx          = r_idx + 1'b1;
                    end
                end
                default: n_idx = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph      <= PH_HUNT;
            r_idx     <= '0;
            r_cmd_len <= '0;
        end else begin
            r_ph      <= n_ph;
            r_idx     <= n_idx;
            r_cmd_len <= n_cmd_len;
        end
    end

endmodule

// ===== sv/clf_queue.sv =====
// Two-entry queue of finished command descriptors between parser and emitter.
module clf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  clf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output clf_pkg::t_job o_job
);
    import clf_pkg::*;

    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && (r_cnt != 2'd2)) r_ent[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && (r_cnt != 2'd2)) r_wp <= ~r_wp;
            if (i_pop && o_valid)          r_rp <= ~r_rp;
            case ({i_push && (r_cnt != 2'd2), i_pop && o_valid})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/clf_back.sv =====
// Emitter: owns the character stores and plays out one run per descriptor.
module clf_back #(
    parameter int CMD_CHARS   = 16,
    parameter int PARAM_CHARS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clf_pkg::t_st_wr i_st_wr,
    input  logic            i_q_valid,
    input  clf_pkg::t_job   i_q_job,
    output logic            o_pop,
    output logic            o_idle,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_part,
    output logic [7:0]      o_out_char,
    output logic            o_has_param,
    output logic            o_last
);
    import clf_pkg::*;

    localparam int CW = $clog2(CMD_CHARS);
    localparam int PW = $clog2(PARAM_CHARS);

    logic [7:0] cmd_mem [CMD_CHARS];
    logic [7:0] par_mem [PARAM_CHARS];

    t_emit            r_st, n_st;
    t_job             r_job, n_job;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_pend, r_pend_par;
    logic [7:0]       r_cmd_q, r_par_q;
    logic             r_out_valid, r_out_hp, r_out_last;
    logic [1:0]       r_out_part;
    logic [7:0]       r_out_char;

    logic fetch_ok, rd_cmd, rd_par, load_end;

    // one record in flight: fetch only when the output slot and read stage are empty
    assign fetch_ok = !r_out_valid && !r_pend;

    always_ff @(posedge i_clk) begin
        if (i_st_wr.we_cmd) cmd_mem[i_st_wr.addr[CW-1:0]] <= i_st_wr.data;
        if (rd_cmd)         r_cmd_q <= cmd_mem[r_idx[CW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_st_wr.we_par) par_mem[i_st_wr.addr[PW-1:0]] <= i_st_wr.data;
        if (rd_par)         r_par_q <= par_mem[r_idx[PW-1:0]];
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_q_valid) n_st = BK_CMD;
            BK_CMD: begin
                if (fetch_ok && !(r_idx < r_job.cmd_len))
                    n_st = r_job.has_param ? BK_PAR : BK_END;
            end
            BK_PAR: if (fetch_ok && !(r_idx < r_job.par_len)) n_st = BK_END;
            BK_END: if (fetch_ok) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = 1'b0;
        rd_cmd   = 1'b0;
        rd_par   = 1'b0;
        load_end = 1'b0;
        n_idx    = r_idx;
        n_job    = r_job;
        case (r_st)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_job = i_q_job;
                    n_idx = '0;
                end
            end
            BK_CMD: begin
                if (fetch_ok) begin
                    if (r_idx < r_job.cmd_len) begin
                        rd_cmd = 1'b1;
                        n_idx  = r_idx + 1'b1;
                    end else begin
                        n_idx = '0;
                    end
                end
            end
            BK_PAR: begin
                if (fetch_ok && (r_idx < r_job.par_len)) begin
                    rd_par = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
            end
            BK_END: load_end = fetch_ok;
            default: n_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        r_pend_par <= rd_par;
        if (r_pend) begin
            r_out_part <= r_pend_par ? PART_PAR : PART_CMD;
            r_out_char <= r_pend_par ? r_par_q : r_cmd_q;
            r_out_hp   <= r_job.has_param;
            r_out_last <= 1'b0;
        end else if (load_end) begin
            r_out_part <= PART_END;
            r_out_char <= 8'h00;
            r_out_hp   <= r_job.has_param;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BK_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_pend <= rd_cmd || rd_par;
            if (r_pend || load_end) r_out_valid <= 1'b1;
            else if (i_ready)       r_out_valid <= 1'b0;
        end
    end

    assign o_idle      = (r_st == BK_IDLE);
    assign o_valid     = r_out_valid;
    assign o_part      = r_out_part;
    assign o_out_char  = r_out_char;
    assign o_has_param = r_out_hp;
    assign o_last      = r_out_last;

endmodule

// ===== sv/clf_checker.sv =====
// Port-level checks on the framer output, bound to the top level.
module clf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_part,
    input logic [7:0] o_out_char,
    input logic       o_has_param,
    input logic       o_last
);
    import clf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_part) && $stable(o_out_char)
            && $stable(o_has_param) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_part == PART_END)))
        else $error("last flag does not match end record");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_part == PART_END) |-> (o_out_char == 8'h00))
        else $error("end record carries a character");

    a_par_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_part == PART_PAR) |-> o_has_param)
        else $error("parameter character without parameter flag");

    a_no_cmd_after_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_part == PART_PAR) ##1 o_valid |-> (o_part != PART_CMD))
        else $error("command character follows parameter character");

endmodule

bind command_line_framer clf_checker u_clf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_part     (o_part),
    .o_out_char (o_out_char),
    .o_has_param(o_has_param),
    .o_last     (o_last)
);

// ===== tb/tb_command_line_framer.sv =====
// Self-checking testbench for command_line_framer: directed lines, random lines, back-pressure.
module tb_command_line_framer;
    import clf_pkg::*;

    localparam int CMD_CHARS   = 16;
    localparam int PARAM_CHARS = 32;
    localparam int CLK_HALF    = 6;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 200;
    localparam int RUN_LIMIT   = 600000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] part;
        logic [7:0] ch;
        logic       has_param;
        logic       last;
    } t_frame_rec;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_char;
    logic       o_valid;
    logic       i_ready;
    logic [1:0] o_part;
    logic [7:0] o_out_char;
    logic       o_has_param;
    logic       o_last;

    // line parser mirror
    t_phase     prs_phase;
    logic [4:0] wr_idx;
    logic [4:0] cmd_len;
    logic [7:0] cmd_buf [CMD_CHARS];
    logic [7:0] par_buf [PARAM_CHARS];

    t_frame_rec pending_recs [$];
    t_frame_rec head_rec;
    int         mismatches;
    int         taken_bytes;
    bit         sender_gaps;
    bit         sink_stalls;
    bit         hold_req;

    command_line_framer #(
        .CMD_CHARS   (CMD_CHARS),
        .PARAM_CHARS (PARAM_CHARS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_char   (i_in_char),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_part      (o_part),
        .o_out_char  (o_out_char),
        .o_has_param (o_has_param),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(2 * CLK_HALF * RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------- prediction ----------------

    function automatic void clear_framer_state();
        prs_phase = PH_HUNT;
        wr_idx    = '0;
        cmd_len   = '0;
        foreach (cmd_buf[i]) cmd_buf[i] = '0;
        foreach (par_buf[i]) par_buf[i] = '0;
    endfunction

    function automatic void queue_run(input logic hp, input logic [4:0] plen);
        for (int i = 0; i < cmd_len; i++)
            pending_recs.push_back('{PART_CMD, cmd_buf[i], hp, 1'b0});
        if (hp) begin
            for (int i = 0; i < plen; i++)
                pending_recs.push_back('{PART_PAR, par_buf[i], hp, 1'b0});
        end
        pending_recs.push_back('{PART_END, 8'h00, hp, 1'b1});
    endfunction

    // after a completion, a '>' opens the next command straight away
    function automatic void reopen(input logic [7:0] b);
        if (b == CH_START) begin
            prs_phase = PH_CMD;
            wr_idx    = '0;
        end else begin
            prs_phase = PH_HUNT;
        end
    endfunction

    function automatic void frame_byte(input logic [7:0] b);
        logic line_end;
        line_end = (b == CH_CR) || (b == CH_LF);
        case (prs_phase)
            PH_HUNT: begin
                if (b == CH_START) begin
                    prs_phase = PH_CMD;
                    wr_idx    = '0;
                end
            end
            PH_CMD: begin
                if (b == CH_SPACE) begin
                    cmd_len   = wr_idx;
                    prs_phase = PH_GAP;
                end else if (line_end || b == CH_START) begin
                    cmd_len = wr_idx;
                    queue_run(1'b0, '0);
                    reopen(b);
                end else if (wr_idx < CMD_CHARS - 1) begin
                    cmd_buf[wr_idx] = b;
                    wr_idx++;
                end
            end
            PH_GAP: begin
                if (b == CH_SPACE) begin
                end else if (line_end || b == CH_START) begin
                    queue_run(1'b0, '0);
                    reopen(b);
                end else begin
                    par_buf[0] = b;
                    wr_idx     = 5'd1;
                    prs_phase  = PH_PARAM;
                end
            end
            default: begin
                if (b == CH_SPACE || line_end || b == CH_START) begin
                    queue_run(1'b1, wr_idx);
                    reopen(b);
                end else if (wr_idx < PARAM_CHARS - 1) begin
                    par_buf[wr_idx] = b;
                    wr_idx++;
                end
            end
        endcase
    endfunction

    // ---------------- checking ----------------

    function automatic void report_mismatch(input string what, input t_frame_rec want);
        if (mismatches < MAX_REPORTS)
            $display({"[%0t] %s: expected part=%0d char=%02h hp=%0b last=%0b, ",
                      "got part=%0d char=%02h hp=%0b last=%0b"},
                     $realtime, what, want.part, want.ch, want.has_param, want.last,
                     o_part, o_out_char, o_has_param, o_last);
        mismatches++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_recs.size() == 0) begin
                report_mismatch("unexpected beat", '0);
            end else begin
                head_rec = pending_recs.pop_front();
                if (o_part !== head_rec.part || o_out_char !== head_rec.ch ||
                    o_has_param !== head_rec.has_param || o_last !== head_rec.last)
                    report_mismatch("record mismatch", head_rec);
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------- sender ----------------

    // leaves valid high after the accepting edge; callers that wait lower it first
    task automatic send_byte(input logic [7:0] b);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_char <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (prs_phase != PH_HUNT || b == CH_START)
            taken_bytes++;
        frame_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_recs.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_START || c == CH_SPACE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] mark_char();
        case ($urandom_range(0, 3))
            0:       return CH_START;
            1:       return CH_SPACE;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic send_line(input int cmd_n, input int sp_n, input int par_n,
                             input logic [7:0] term);
        send_byte(CH_START);
        repeat (cmd_n) send_byte(plain_char());
        repeat (sp_n) send_byte(CH_SPACE);
        repeat (par_n) send_byte(plain_char());
        send_byte(term);
    endtask

    task automatic send_random_line();
        int cmd_n;
        int sp_n;
        int par_n;
        int shape;
        if ($urandom_range(0, 9) < 2) begin
            // noise and broken lines
            repeat ($urandom_range(1, 6))
                send_byte($urandom_range(0, 2) == 0 ? mark_char() : 8'($urandom_range(0, 255)));
            return;
        end
        cmd_n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
        shape = $urandom_range(0, 3);
        sp_n  = (shape == 0) ? 0 : $urandom_range(1, 3);
        par_n = 0;
        if (shape >= 2)
            par_n = ($urandom_range(0, 7) == 0) ? $urandom_range(29, 36) : $urandom_range(1, 8);
        send_line(cmd_n, sp_n, par_n, mark_char());
    endtask

    // ---------------- tests ----------------

    task automatic test_hunting();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_SPACE);
        send_byte(CH_CR);
        send_text(">ab");
        send_byte(CH_CR);
    endtask

    task automatic test_empty_command();
        send_text(">>");
        send_byte(CH_LF);
        send_text("> ");
        send_byte(CH_CR);
    endtask

    task automatic test_parameter_words();
        send_text(">go  x1 ");
        send_text(">s 7>q z");
        send_byte(CH_LF);
        send_text(">c >");
        send_byte(CH_CR);
    endtask

    task automatic test_zero_and_high_bytes();
        send_byte(CH_START);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_SPACE);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(CH_CR);
    endtask

    // both stores overfilled: the longest run the block can produce
    task automatic test_store_overflow();
        send_line(CMD_CHARS, 1, PARAM_CHARS, CH_LF);
        send_line(CMD_CHARS - 1, 0, 0, CH_START);
        send_byte(CH_CR);
    endtask

    task automatic test_random_lines(input int n_bytes);
        int start;
        start = taken_bytes;
        while (taken_bytes - start < n_bytes) send_random_line();
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        repeat (2) send_line($urandom_range(2, 8), 1, $urandom_range(1, 6), CH_CR);
    endtask

    task automatic test_sender_pause();
        send_line(3, 1, 3, CH_SPACE);
        wait_drained();
        send_line(2, 0, 0, CH_LF);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_in_char   <= 8'h00;
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_req    = 1'b0;
        mismatches  = 0;
        taken_bytes = 0;
        clear_framer_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hunting();
        test_empty_command();
        test_parameter_words();
        test_zero_and_high_bytes();

        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_store_overflow();
        test_output_hold();
        test_sender_pause();
        test_random_lines(12);

        // closing stretch at full rate
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_lines(8);
        send_byte(CH_CR);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_recs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== command_line_framer.f =====
sv/clf_pkg.sv
sv/clf_front.sv
sv/clf_queue.sv
sv/clf_back.sv
sv/command_line_framer.sv
sv/clf_checker.sv
tb/tb_command_line_framer.sv
